// File: design/fcsg_pkg.sv
// Package for the four-channel sound generator: request codes, field types,
// register offsets and constant tables. No dependencies.
package fcsg_pkg;

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_TICK  = 2'd2,
      REQ_DIVRST = 2'd3
   } req_code_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [5:0] reg_address;
      logic [7:0] write_data;
      logic       fs_bit_before;
      logic       fs_bit_after;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [3:0] square1_level;
      logic [3:0] square2_level;
      logic [3:0] wave_level;
      logic [3:0] noise_level;
      logic [3:0] channels_on;
      logic       power_on;
   } rsp_payload_type;

   localparam logic [5:0] ADDR_NR10 = 6'd0;
   localparam logic [5:0] ADDR_NR11 = 6'd1;
   localparam logic [5:0] ADDR_NR12 = 6'd2;
   localparam logic [5:0] ADDR_NR13 = 6'd3;
   localparam logic [5:0] ADDR_NR14 = 6'd4;
   localparam logic [5:0] ADDR_GAP1 = 6'd5;
   localparam logic [5:0] ADDR_NR21 = 6'd6;
   localparam logic [5:0] ADDR_NR22 = 6'd7;
   localparam logic [5:0] ADDR_NR23 = 6'd8;
   localparam logic [5:0] ADDR_NR24 = 6'd9;
   localparam logic [5:0] ADDR_NR30 = 6'd10;
   localparam logic [5:0] ADDR_NR32 = 6'd12;
   localparam logic [5:0] ADDR_NR33 = 6'd13;
   localparam logic [5:0] ADDR_NR34 = 6'd14;
   localparam logic [5:0] ADDR_GAP2 = 6'd15;
   localparam logic [5:0] ADDR_NR42 = 6'd17;
   localparam logic [5:0] ADDR_NR43 = 6'd18;
   localparam logic [5:0] ADDR_NR44 = 6'd19;
   localparam logic [5:0] ADDR_NR50 = 6'd20;
   localparam logic [5:0] ADDR_NR51 = 6'd21;
   localparam logic [5:0] ADDR_NR52 = 6'd22;
   localparam logic [5:0] ADDR_WAVE_LO = 6'd32;
   localparam logic [5:0] ADDR_WAVE_HI = 6'd47;
   localparam int         NUM_REGS = 22;

   localparam logic [7:0] NR50_RESET = 8'h77;
   localparam logic [7:0] NR51_RESET = 8'hF3;
   localparam logic [10:0] FREQ_MAX = 11'h7FF;
   localparam logic [14:0] LFSR_SEED = 15'h7FFF;

   function automatic logic [7:0] duty_mask(input logic [1:0] duty);
      case (duty)
         2'd0: duty_mask = 8'h80;
         2'd1: duty_mask = 8'h81;
         2'd2: duty_mask = 8'hE1;
         2'd3: duty_mask = 8'h7E;
         default: duty_mask = 8'h80;
      endcase
   endfunction

   function automatic logic [6:0] noise_div(input logic [2:0] code);
      case (code)
         3'd0: noise_div = 7'd8;
         3'd1: noise_div = 7'd16;
         3'd2: noise_div = 7'd32;
         3'd3: noise_div = 7'd48;
         3'd4: noise_div = 7'd64;
         3'd5: noise_div = 7'd80;
         3'd6: noise_div = 7'd96;
         3'd7: noise_div = 7'd112;
         default: noise_div = 7'd8;
      endcase
   endfunction

endpackage

// File: design/fcsg_stream_if.sv
// Valid/ready stream interfaces for the request and response channels.
// Depends on fcsg_pkg for the payload types.
interface fcsg_req_if;
   import fcsg_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface fcsg_rsp_if;
   import fcsg_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: design/fcsg_core.sv
// Sound generator state and single-pass request execution.
// Depends on fcsg_pkg. Applies one request per cycle when step is high.
module fcsg_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  fcsg_pkg::req_payload_type req,
   output fcsg_pkg::rsp_payload_type rsp
);
   import fcsg_pkg::*;

   logic [7:0]  regs_ff [NUM_REGS];
   logic [10:0] freq_ff [3];
   logic [3:0]  en_ff;
   logic [8:0]  len_ff [4];
   logic [13:0] sqt_ff [2];
   logic [2:0]  duty_ff [2];
   logic [3:0]  envv_ff [3];
   logic [3:0]  envt_ff [3];
   logic [2:0]  envr_ff;
   logic [3:0]  swt_ff;
   logic [11:0] sws_ff;
   logic [1:0]  swf_ff;
   logic [12:0] wvt_ff;
   logic [4:0]  wvp_ff;
   logic [3:0]  wvs_ff;
   logic [7:0]  wtab_ff [16];
   logic [21:0] nzt_ff;
   logic [14:0] nzs_ff;
   logic [2:0]  fstep_ff;
   logic        pwr_ff;

   logic [7:0]  regs_in [NUM_REGS];
   logic [10:0] freq_in [3];
   logic [3:0]  en_in;
   logic [8:0]  len_in [4];
   logic [13:0] sqt_in [2];
   logic [2:0]  duty_in [2];
   logic [3:0]  envv_in [3];
   logic [3:0]  envt_in [3];
   logic [2:0]  envr_in;
   logic [3:0]  swt_in;
   logic [11:0] sws_in;
   logic [1:0]  swf_in;
   logic [12:0] wvt_in;
   logic [4:0]  wvp_in;
   logic [3:0]  wvs_in;
   logic [7:0]  wtab_in [16];
   logic [21:0] nzt_in;
   logic [14:0] nzs_in;
   logic [2:0]  fstep_in;
   logic        pwr_in;
   rsp_payload_type rsp_in;

   function automatic logic [7:0] env_of(input logic [1:0] e, input logic [7:0] r2,
                                         input logic [7:0] r7, input logic [7:0] r17);
      case (e)
         2'd0: env_of = r2;
         2'd1: env_of = r7;
         default: env_of = r17;
      endcase
   endfunction

   always_comb begin
      logic [5:0]  a;
      logic [7:0]  v;
      logic [2:0]  ch;
      logic [2:0]  k;
      logic [2:0]  s;
      logic [2:0]  per;
      logic [7:0]  er;
      logic [12:0] sum;
      logic [11:0] sh;
      logic        was_len;
      logic        frame;
      logic [7:0]  b;
      logic        x;
      logic [14:0] ns;
      logic [1:0]  code;
      logic [7:0]  rd;
      logic [3:0]  lv [4];
      logic [4:0]  wp;
      logic [3:0]  wpos;
      logic [1:0]  ei;
      logic [7:0]  dm;
      logic [7:0]  nr10;
      logic [7:0]  nr43;

      regs_in = regs_ff; freq_in = freq_ff; en_in = en_ff; len_in = len_ff;
      sqt_in = sqt_ff; duty_in = duty_ff; envv_in = envv_ff; envt_in = envt_ff;
      envr_in = envr_ff; swt_in = swt_ff; sws_in = sws_ff; swf_in = swf_ff;
      wvt_in = wvt_ff; wvp_in = wvp_ff; wvs_in = wvs_ff; wtab_in = wtab_ff;
      nzt_in = nzt_ff; nzs_in = nzs_ff; fstep_in = fstep_ff; pwr_in = pwr_ff;
      a = req.reg_address; v = req.write_data;
      ch = 3'd0; k = 3'd0; s = 3'd0; per = 3'd0; er = 8'd0; sum = 13'd0; sh = 12'd0;
      was_len = 1'b0; frame = 1'b0; b = 8'd0; x = 1'b0; ns = 15'd0; code = 2'd0;
      rd = 8'hFF; wp = 5'd0; ei = 2'd0; dm = 8'd0;
      nr10 = regs_ff[ADDR_NR10[4:0]];
      nr43 = regs_ff[ADDR_NR43[4:0]];
      wpos = wvp_ff[4:1];
      lv = '{default: 4'd0};

      case (req.req_type)
         REQ_WRITE: begin
            if (a == ADDR_NR52) begin
               if (pwr_ff && !v[7]) begin
                  // power off: clear registers, frequencies and enables, and reload lengths
                  regs_in = '{default: 8'd0};
                  freq_in = '{default: 11'd0};
                  len_in = '{9'd64, 9'd64, 9'd256, 9'd64};
                  en_in = 4'd0;
               end else if (!pwr_ff && v[7]) begin
                  fstep_in = 3'd0;
               end
               pwr_in = v[7];
            end else if (a >= ADDR_WAVE_LO && a <= ADDR_WAVE_HI) begin
               if (en_ff[2]) wtab_in[wpos] = v;
               else wtab_in[a[3:0]] = v;
            end else if (pwr_ff && a < ADDR_NR52 && a != ADDR_GAP1 && a != ADDR_GAP2) begin
               ch = (a >= ADDR_NR50) ? 3'd4 : (a >= ADDR_GAP2) ? 3'd3 :
                    (a >= ADDR_NR30) ? 3'd2 : (a >= ADDR_GAP1) ? 3'd1 : 3'd0;
               k = 3'(a - 6'(ch) * 6'd5);
               ei = (ch == 3'd3) ? 2'd2 : ch[1:0];
               was_len = regs_ff[a[4:0]][6];
               regs_in[a[4:0]] = v;
               if (ch != 3'd4) begin
                  case (k)
                     3'd0: begin
                        if (ch == 3'd0 && !v[3] && swf_ff[1]) en_in[0] = 1'b0;
                        if (ch == 3'd2 && !v[7]) en_in[2] = 1'b0;
                     end
                     3'd1: begin
                        if (ch == 3'd2) len_in[2] = 9'd256 - 9'(v);
                        else len_in[ch[1:0]] = 9'd64 - 9'(v[5:0]);
                     end
                     3'd2: begin
                        if (ch != 3'd2 && v[7:3] == 5'd0) en_in[ch[1:0]] = 1'b0;
                     end
                     3'd3: begin
                        if (ch < 3'd3) freq_in[ch[1:0]] = {freq_ff[ch[1:0]][10:8], v};
                     end
                     default: begin
                        if (ch < 3'd3) freq_in[ch[1:0]] = {v[2:0], freq_ff[ch[1:0]][7:0]};
                        if (!was_len && v[6] && fstep_ff[0] && len_in[ch[1:0]] != 9'd0) begin
                           len_in[ch[1:0]] = len_in[ch[1:0]] - 9'd1;
                           if (len_in[ch[1:0]] == 9'd0) en_in[ch[1:0]] = 1'b0;
                        end
                        if (v[7]) begin
                           if (ch == 3'd2) begin
                              en_in[2] = regs_ff[ADDR_NR30[4:0]][7];
                              wvt_in = 13'((12'd2048 - 12'(freq_in[2])) * 2);
                              wvp_in = 5'd0;
                              wvs_in = wtab_ff[0][7:4];
                              if (len_in[2] == 9'd0) len_in[2] = 9'd256;
                           end else begin
                              er = (ch == 3'd3) ? regs_ff[ADDR_NR42[4:0]] :
                                   regs_ff[5'(5 * ch + 2)];
                              en_in[ch[1:0]] = er[7:3] != 5'd0;
                              envt_in[ei] = (er[2:0] != 3'd0) ? {1'b0, er[2:0]} : 4'd8;
                              envr_in[ei] = 1'b1;
                              envv_in[ei] = er[7:4];
                              if (len_in[ch[1:0]] == 9'd0) len_in[ch[1:0]] = 9'd64;
                              if (ch == 3'd3) begin
                                 nzs_in = LFSR_SEED;
                                 nzt_in = 22'(noise_div(nr43[2:0])) << nr43[7:4];
                              end else begin
                                 sqt_in[ch[0]] = 14'((12'd2048 - 12'(freq_in[ch[1:0]])) * 4);
                                 duty_in[ch[0]] = 3'd0;
                              end
                              if (ch == 3'd0) begin
                                 per = nr10[6:4];
                                 sws_in = {1'b0, freq_in[0]};
                                 swt_in = (per != 3'd0) ? {1'b0, per} : 4'd8;
                                 swf_in = {1'b0, (per != 3'd0 || nr10[2:0] != 3'd0)};
                                 if (nr10[2:0] != 3'd0) begin
                                    sh = sws_in >> nr10[2:0];
                                    if (nr10[3]) sum = {1'b0, sws_in - sh};
                                    else sum = 13'(sws_in) + 13'(sh);
                                    if (nr10[3]) swf_in[1] = 1'b1;
                                    if (sum > 13'(FREQ_MAX)) en_in[0] = 1'b0;
                                 end
                              end
                           end
                        end
                     end
                  endcase
               end
            end
         end
         REQ_READ: begin
            if (a == ADDR_NR52) rd = {pwr_ff, 3'b111, en_ff};
            else if (a >= ADDR_WAVE_LO && a <= ADDR_WAVE_HI)
               rd = en_ff[2] ? wtab_ff[wpos] : wtab_ff[a[3:0]];
            else begin
               case (a)
                  ADDR_NR10: rd = regs_ff[a[4:0]] | 8'h80;
                  ADDR_NR11, ADDR_NR21: rd = regs_ff[a[4:0]] | 8'h3F;
                  ADDR_NR12, ADDR_NR22, ADDR_NR42, ADDR_NR43, ADDR_NR50, ADDR_NR51:
                     rd = regs_ff[a[4:0]];
                  ADDR_NR14, ADDR_NR24, ADDR_NR34, ADDR_NR44:
                     rd = (regs_ff[a[4:0]] & 8'h40) | 8'hBF;
                  ADDR_NR30: rd = regs_ff[a[4:0]] | 8'h7F;
                  ADDR_NR32: rd = regs_ff[a[4:0]] | 8'h9F;
                  default: rd = 8'hFF;
               endcase
            end
         end
         REQ_TICK: frame = pwr_ff && req.fs_bit_before && !req.fs_bit_after;
         default: frame = pwr_ff && req.fs_bit_before;
      endcase

      if (frame) begin
         s = fstep_ff;
         if (!s[0]) begin
            for (int c = 0; c < 4; c++) begin
               if (regs_ff[5'(5 * c + 4)][6] && len_ff[c] != 9'd0) begin
                  len_in[c] = len_ff[c] - 9'd1;
                  if (len_in[c] == 9'd0) en_in[c] = 1'b0;
               end
            end
            if ((s == 3'd2 || s == 3'd6) && swf_ff[0]) begin
               per = nr10[6:4];
               swt_in = (swt_ff != 4'd0) ? swt_ff - 4'd1 : 4'd0;
               if (swt_in == 4'd0) begin
                  swt_in = (per != 3'd0) ? {1'b0, per} : 4'd8;
                  if (per != 3'd0) begin
                     sh = sws_ff >> nr10[2:0];
                     if (nr10[3]) sum = {1'b0, sws_ff - sh};
                     else sum = 13'(sws_ff) + 13'(sh);
                     if (nr10[3]) swf_in[1] = 1'b1;
                     if (sum > 13'(FREQ_MAX)) en_in[0] = 1'b0;
                     else if (nr10[2:0] != 3'd0) begin
                        sws_in = sum[11:0];
                        freq_in[0] = sum[10:0];
                        sh = sum[11:0] >> nr10[2:0];
                        if (nr10[3]) sum = {1'b0, sum[11:0] - sh};
                        else sum = 13'(sum[11:0]) + 13'(sh);
                        if (sum > 13'(FREQ_MAX)) en_in[0] = 1'b0;
                     end
                  end
               end
            end
         end else if (s == 3'd7) begin
            for (int e = 0; e < 3; e++) begin
               er = env_of(2'(e), regs_ff[ADDR_NR12[4:0]], regs_ff[ADDR_NR22[4:0]],
                           regs_ff[ADDR_NR42[4:0]]);
               if (envr_ff[e] && er[2:0] != 3'd0) begin
                  envt_in[e] = (envt_ff[e] != 4'd0) ? envt_ff[e] - 4'd1 : 4'd0;
                  if (envt_in[e] == 4'd0) begin
                     envt_in[e] = {1'b0, er[2:0]};
                     if (er[3]) begin
                        if (envv_ff[e] != 4'd15) envv_in[e] = envv_ff[e] + 4'd1;
                        else envr_in[e] = 1'b0;
                     end else begin
                        if (envv_ff[e] != 4'd0) envv_in[e] = envv_ff[e] - 4'd1;
                        else envr_in[e] = 1'b0;
                     end
                  end
               end
            end
         end
         fstep_in = s + 3'd1;
      end

      if (req.req_type == REQ_TICK && pwr_ff) begin
         for (int c = 0; c < 2; c++) begin
            if (en_in[c]) begin
               sqt_in[c] = (sqt_ff[c] != 14'd0) ? sqt_ff[c] - 14'd1 : 14'd0;
               if (sqt_in[c] == 14'd0) begin
                  sqt_in[c] = 14'((12'd2048 - 12'(freq_in[c])) * 4);
                  duty_in[c] = duty_ff[c] + 3'd1;
               end
            end
         end
         if (en_in[2]) begin
            wvt_in = (wvt_ff != 13'd0) ? wvt_ff - 13'd1 : 13'd0;
            if (wvt_in == 13'd0) begin
               wvt_in = 13'((12'd2048 - 12'(freq_in[2])) * 2);
               wp = wvp_ff + 5'd1;
               wvp_in = wp;
               b = wtab_ff[wp[4:1]];
               wvs_in = wp[0] ? b[3:0] : b[7:4];
            end
         end
         if (en_in[3]) begin
            nzt_in = (nzt_ff != 22'd0) ? nzt_ff - 22'd1 : 22'd0;
            if (nzt_in == 22'd0) begin
               nzt_in = 22'(noise_div(nr43[2:0])) << nr43[7:4];
               x = nzs_ff[0] ^ nzs_ff[1];
               ns = {x, nzs_ff[14:1]};
               if (nr43[3]) ns[6] = x;
               nzs_in = ns;
            end
         end
      end

      for (int c = 0; c < 2; c++) begin
         dm = duty_mask(regs_in[5'(5 * c + 1)][7:6]);
         if (en_in[c] && regs_in[5'(5 * c + 2)][7:3] != 5'd0 && dm[duty_in[c]])
            lv[c] = envv_in[c];
      end
      code = regs_in[ADDR_NR32[4:0]][6:5];
      if (en_in[2] && regs_in[ADDR_NR30[4:0]][7] && code != 2'd0)
         lv[2] = wvs_in >> (code - 2'd1);
      if (en_in[3] && regs_in[ADDR_NR42[4:0]][7:3] != 5'd0 && !nzs_in[0])
         lv[3] = envv_in[2];

      rsp_in.read_data = rd;
      rsp_in.square1_level = lv[0];
      rsp_in.square2_level = lv[1];
      rsp_in.wave_level = lv[2];
      rsp_in.noise_level = lv[3];
      rsp_in.channels_on = en_in;
      rsp_in.power_on = pwr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= 8'd0;
         regs_ff[ADDR_NR50[4:0]] <= NR50_RESET;
         regs_ff[ADDR_NR51[4:0]] <= NR51_RESET;
         for (int i = 0; i < 3; i++) begin
            freq_ff[i] <= 11'd0; envv_ff[i] <= 4'd0; envt_ff[i] <= 4'd0;
         end
         for (int i = 0; i < 4; i++) len_ff[i] <= 9'd0;
         for (int i = 0; i < 2; i++) begin
            sqt_ff[i] <= 14'd0; duty_ff[i] <= 3'd0;
         end
         for (int i = 0; i < 16; i++) wtab_ff[i] <= 8'd0;
         en_ff <= 4'd0; envr_ff <= 3'd0; swt_ff <= 4'd0; sws_ff <= 12'd0; swf_ff <= 2'd0;
         wvt_ff <= 13'd0; wvp_ff <= 5'd0; wvs_ff <= 4'd0; nzt_ff <= 22'd0; nzs_ff <= 15'd0;
         fstep_ff <= 3'd0; pwr_ff <= 1'b1;
      end else if (step) begin
         regs_ff <= regs_in; freq_ff <= freq_in; en_ff <= en_in; len_ff <= len_in;
         sqt_ff <= sqt_in; duty_ff <= duty_in; envv_ff <= envv_in; envt_ff <= envt_in;
         envr_ff <= envr_in; swt_ff <= swt_in; sws_ff <= sws_in; swf_ff <= swf_in;
         wvt_ff <= wvt_in; wvp_ff <= wvp_in; wvs_ff <= wvs_in; wtab_ff <= wtab_in;
         nzt_ff <= nzt_in; nzs_ff <= nzs_in; fstep_ff <= fstep_in; pwr_ff <= pwr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) rsp <= rsp_in;
   end

`ifndef NO_ASSERTIONS
   a_off_quiet: assert property (@(posedge clock) disable iff (reset)
      step && !pwr_in |=> en_ff == 4'd0) else $error("channel on while powered off");
   a_len_stop: assert property (@(posedge clock) disable iff (reset)
      en_ff[1] |-> len_ff[1] != 9'd0)
      else $error("square2 live with empty length");
   a_noise_seed: assert property (@(posedge clock) disable iff (reset)
      step && req.req_type == REQ_WRITE && pwr_ff && req.reg_address == ADDR_NR44 &&
      req.write_data[7] |=> nzs_ff == LFSR_SEED) else $error("noise trigger seed");
`endif
endmodule

// File: design/four_channel_sound_generator_unit.sv
// Top level of the four-channel sound generator.
// Depends on fcsg_pkg, fcsg_req_if, fcsg_rsp_if and fcsg_core.
//
//   channel | dir | payload
//   req     | in  | req_type, reg_address, write_data, fs_bit_before, fs_bit_after
//   rsp     | out | read_data, four channel levels, channels_on, power_on
//
// A request is applied in the cycle it is accepted and its response sits in the
// output register the next cycle. One request per clock while no response stalls.
// Synchronous reset restores the power-on register set; no clearing pass.
// A stalled response holds; req_ready follows rsp_ready when a response waits.
module four_channel_sound_generator_unit (
   input logic       clock,
   input logic       reset,
   fcsg_req_if.sink  req,
   fcsg_rsp_if.source rsp
);
   import fcsg_pkg::*;

   logic valid_ff;
   logic valid_in;
   logic step;

   assign req.ready = !valid_ff || rsp.ready;
   assign step = req.valid && req.ready;
   assign valid_in = step || (valid_ff && !rsp.ready);
   assign rsp.valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   fcsg_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req.payload),
      .rsp   (rsp.payload)
   );

`ifndef NO_ASSERTIONS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
      else $error("response dropped under stall");
   a_take: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> rsp.valid) else $error("accepted request lost");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready) else $error("stalled with empty output");
`endif
endmodule
